FILE: design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define MRV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MRV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/mrv_pkg.sv
`timescale 1ns / 1ps

package mrv_pkg;

  // Longest legal frame and the width of the byte position.
  localparam int unsigned MaxFrame = 256;
  localparam int unsigned PosW     = 9;
  localparam int unsigned LenW     = PosW + 1;

  // CRC-16/MODBUS.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Function codes with their own rules.
  localparam logic [7:0] FnReadBitsLast = 8'd2;
  localparam logic [7:0] FnReadRegsLast = 8'd4;
  localparam logic [7:0] FnWriteCoil    = 8'd5;
  localparam logic [7:0] FnWriteReg     = 8'd6;
  localparam logic [7:0] FnWriteCoils   = 8'd15;
  localparam logic [7:0] FnWriteRegs    = 8'd16;
  localparam logic [7:0] FnUserDefined  = 8'h41;

  // Quantity limits, coil values and bus addresses.
  localparam logic [15:0] QtyBitsLimit  = 16'd254;
  localparam logic [15:0] QtyRegsLimit  = 16'd127;
  localparam logic [15:0] QtyMultLimit  = 16'd126;
  localparam logic [15:0] CoilOn        = 16'hFF00;
  localparam logic [15:0] CoilOff       = 16'h0000;
  localparam logic [7:0]  BroadcastAddr = 8'd0;
  localparam logic [7:0]  DefaultAddr   = 8'd1;

  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    VerdictAccept      = 2'd0,
    VerdictReject      = 2'd1,
    VerdictUnsupported = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CrcUndecided = 2'd0,
    CrcMatch     = 2'd1,
    CrcMismatch  = 2'd2
  } crc_state_e;

  // One received word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  // Frame summary handed to the result register.
  typedef struct packed {
    verdict_e   verdict;
    logic       addr_match;
    logic [7:0] func;
    pos_t       length;
  } result_t;

  // Fold one byte into the CRC, all eight shifts in one go.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/mrv_in_stage.sv
`timescale 1ns / 1ps

module mrv_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          frame_end_i,
  input  logic          res_free_i,
  output logic          advance_o,
  output mrv_pkg::word_t word_o
);
  import mrv_pkg::*;

  logic  valid_q;
  word_t word_q;

  // A non-final word never waits; a final one waits for a free result slot.
  assign advance_o  = valid_q && (!word_q.last || res_free_i);
  assign in_ready_o = !valid_q || advance_o;
  assign word_o     = word_q;

  // Hold the word until the frame logic has consumed it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q.data <= data_byte_i;
      word_q.last <= frame_end_i;
    end
  end

endmodule

FILE: design/mrv_frame_state.sv
`timescale 1ns / 1ps

module mrv_frame_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  mrv_pkg::word_t    word_i,
  input  logic [7:0]        device_address_i,
  output mrv_pkg::result_t  result_o
);
  import mrv_pkg::*;

  pos_t        pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [7:0]  slave_q, slave_d, func_q, func_d, count_q, count_d;
  logic [15:0] qty_q, qty_d;
  crc_state_e  crcv_q, crcv_d;

  logic            in_range, crc_run, tail_match, ok;
  logic [LenW-1:0] pos_inc, check_len;
  verdict_e        verdict;

  // Capture header fields and advance the CRC two bytes behind.
  always_comb begin
    in_range = pos_q <= PosW'(MaxFrame);
    crc_run  = pos_q < PosW'(MaxFrame);
    pos_inc  = {1'b0, pos_q} + LenW'(1);
    slave_d  = slave_q;
    func_d   = func_q;
    qty_d    = qty_q;
    count_d  = count_q;
    crc_d    = crc_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    pos_d    = pos_q;
    if (in_range) begin
      if (pos_q == PosW'(0)) slave_d = word_i.data;
      if (pos_q == PosW'(1)) func_d = word_i.data;
      if (pos_q == PosW'(4)) qty_d[15:8] = word_i.data;
      if (pos_q == PosW'(5)) qty_d[7:0] = word_i.data;
      if (pos_q == PosW'(6)) count_d = word_i.data;
      if (crc_run) begin
        if (pos_q >= PosW'(2)) crc_d = crc_feed(crc_q, held0_q);
        held0_d = held1_q;
        held1_d = word_i.data;
      end
      pos_d = pos_inc[PosW-1:0];
    end
  end

  // Length at which the trailing CRC is checked; zero when not fixed.
  always_comb begin
    priority if (func_d <= FnWriteReg) begin
      check_len = LenW'(8);
    end else if (func_d == FnWriteCoils || func_d == FnWriteRegs) begin
      check_len = LenW'(9) + {2'b00, count_d};
    end else begin
      check_len = '0;
    end
  end

  // Latch the CRC verdict once the checked length is reached.
  always_comb begin
    tail_match = {held1_d, held0_d} == crc_d;
    crcv_d     = crcv_q;
    if (in_range && crc_run && crcv_q == CrcUndecided && pos_inc == check_len) begin
      crcv_d = tail_match ? CrcMatch : CrcMismatch;
    end
  end

  // Judge the frame as it stands after this byte.
  always_comb begin
    ok = crcv_d == CrcMatch;
    priority if (pos_d > PosW'(MaxFrame)) begin
      verdict = VerdictReject;
    end else if (func_d <= FnReadBitsLast) begin
      verdict = (qty_d < QtyBitsLimit && ok) ? VerdictAccept : VerdictReject;
    end else if (func_d <= FnReadRegsLast) begin
      verdict = (qty_d < QtyRegsLimit && ok) ? VerdictAccept : VerdictReject;
    end else if (func_d == FnWriteCoil) begin
      verdict = ((qty_d == CoilOn || qty_d == CoilOff) && ok) ? VerdictAccept
                                                              : VerdictReject;
    end else if (func_d == FnWriteReg) begin
      verdict = ok ? VerdictAccept : VerdictReject;
    end else if (func_d == FnWriteCoils) begin
      verdict = (count_d != 8'd0 && qty_d != 16'd0 && ok) ? VerdictAccept : VerdictReject;
    end else if (func_d == FnWriteRegs) begin
      verdict = (qty_d != 16'd0 && qty_d < QtyMultLimit &&
                 {8'h00, count_d} == {qty_d[14:0], 1'b0} && ok) ? VerdictAccept
                                                                 : VerdictReject;
    end else if (func_d == FnUserDefined) begin
      verdict = (pos_d >= PosW'(3) && tail_match) ? VerdictAccept : VerdictReject;
    end else begin
      verdict = VerdictUnsupported;
    end
  end

  assign result_o.verdict    = verdict;
  assign result_o.addr_match = (slave_d == device_address_i) || (slave_d == BroadcastAddr);
  assign result_o.func       = func_d;
  assign result_o.length     = pos_d;

  // Advance on each word; clear everything after the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      held0_q <= '0;
      held1_q <= '0;
      slave_q <= '0;
      func_q  <= '0;
      qty_q   <= '0;
      count_q <= '0;
      crcv_q  <= CrcUndecided;
    end else if (advance_i) begin
      if (word_i.last) begin
        pos_q   <= '0;
        crc_q   <= CrcInit;
        held0_q <= '0;
        held1_q <= '0;
        slave_q <= '0;
        func_q  <= '0;
        qty_q   <= '0;
        count_q <= '0;
        crcv_q  <= CrcUndecided;
      end else begin
        pos_q   <= pos_d;
        crc_q   <= crc_d;
        held0_q <= held0_d;
        held1_q <= held1_d;
        slave_q <= slave_d;
        func_q  <= func_d;
        qty_q   <= qty_d;
        count_q <= count_d;
        crcv_q  <= crcv_d;
      end
    end
  end

endmodule

FILE: design/mrv_out_stage.sv
`timescale 1ns / 1ps

module mrv_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mrv_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mrv_pkg::result_t result_o
);
  import mrv_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  // Hold the result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: design/modbus_rtu_request_validator.sv
`timescale 1ns / 1ps
// Modbus RTU request checker. Takes one frame byte per clock with no gaps
// needed, and on the byte marked as frame end returns one result word:
// accept, reject or unsupported function, an address-match flag, the
// function code and the length (saturating at 257). The CRC-16/MODBUS
// update for a byte is combinational, which sets the rate of one byte per
// cycle; a result is registered in the output stage once its final byte
// leaves the input register. A waiting result holds back the next final
// byte and the bytes behind it, but not the bytes of the frame before it.
// Write device_address only while no frame is open.
`include "assert_macros.svh"

module modbus_rtu_request_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o,
  output logic       address_match_o,
  output logic [7:0] function_code_o,
  output logic [8:0] frame_length_o
);
  import mrv_pkg::*;

  logic       final_load;
  logic [7:0] dev_addr_q;
  logic       res_free, advance;
  word_t      word;
  result_t    res_next, res_out;

  // Slave address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DefaultAddr;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Flag a final word leaving the input register; it loads the result register and feeds the checks below.
  assign final_load = advance && word.last;

  mrv_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .res_free_i  (res_free),
    .advance_o   (advance),
    .word_o      (word)
  );

  mrv_frame_state u_frame (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .word_i           (word),
    .device_address_i (dev_addr_q),
    .result_o         (res_next)
  );

  mrv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (final_load),
    .result_i    (res_next),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_out)
  );

  assign verdict_o       = res_out.verdict;
  assign address_match_o = res_out.addr_match;
  assign function_code_o = res_out.func;
  assign frame_length_o  = res_out.length;

  // A final word only leaves the input register into a free result slot.
  `MRV_ASSERT(a_final_needs_slot, final_load |-> res_free, "final word without slot")
  // A loaded final word is presented on the next cycle.
  `MRV_ASSERT(a_load_shows, final_load |=> out_valid_o, "result not presented")
  // No frame is ever empty or longer than the saturation value.
  `MRV_ASSERT(a_len_range,
    out_valid_o |-> (frame_length_o != 9'd0 && frame_length_o <= 9'd257),
    "frame length out of range")
  // An accepted frame has a legal length and a one-byte frame is rejected.
  `MRV_ASSERT(a_accept_len,
    (out_valid_o && verdict_o == VerdictAccept) |->
      (frame_length_o >= 9'd3 && frame_length_o <= 9'd256),
    "accepted frame of illegal length")
  // Nothing is presented on the first edge after reset is released.
  `MRV_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> !out_valid_o, "result valid after reset")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mrv_pkg::*;

  // Function codes that the package leaves unnamed
  localparam logic [7:0] FnLowest      = 8'd0;
  localparam logic [7:0] FnReadCoils   = 8'd1;
  localparam logic [7:0] FnReadHolding = 8'd3;
  localparam logic [7:0] FnUnknown     = 8'h07;
  localparam logic [7:0] FnTop         = 8'hFF;

  localparam logic [7:0] AddrLow  = 8'd1;
  localparam logic [7:0] AddrHigh = 8'd247;

  localparam int RandomWords = 950;
  localparam int Phases      = 5;
  localparam int HoldCycles  = 400;
  localparam int SettleCycles = 4;
  localparam int TailCycles  = 20;

  typedef struct packed {
    verdict_e   verdict;
    logic       addr_match;
    logic [7:0] func;
    logic [8:0] length;
  } frame_report_t;

  // A typed-in report, when set, replaces the predicted one for its frame
  typedef struct packed {
    logic          typed_in;
    frame_report_t report;
  } report_hint_t;

  typedef struct packed {
    logic [7:0]    addr;
    logic [7:0]    func;
    logic [15:0]   qty;
    logic [7:0]    count;
    logic [9:0]    length;
    logic          crc_ok;
    logic          typed_in;
    frame_report_t report;
  } frame_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       frame_end_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] verdict_o;
  logic       address_match_o;
  logic [7:0] function_code_o;
  logic [8:0] frame_length_o;

  modbus_rtu_request_validator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o),
    .address_match_o (address_match_o),
    .function_code_o (function_code_o),
    .frame_length_o  (frame_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the frame checker
  logic [7:0]  own_addr;
  logic [8:0]  rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  tail_lo;
  logic [7:0]  tail_hi;
  logic [7:0]  rx_slave;
  logic [7:0]  rx_func;
  logic [15:0] rx_qty;
  logic [7:0]  rx_count;
  crc_state_e  rx_crc_state;

  frame_report_t report_q[$];
  report_hint_t  hint_q[$];
  logic [7:0]    frame_q[$];
  frame_row_t    rows[$];

  int fault_count = 0;
  int words_sent  = 0;
  int hold_tokens = 0;
  int hold_served = 0;
  bit calm        = 1'b0;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // Length at which the CRC is checked; 0 when the frame end decides it
  function automatic int crc_span(logic [7:0] fn, logic [7:0] cnt);
    if (fn <= FnWriteReg) return 8;
    if (fn == FnWriteCoils || fn == FnWriteRegs) return 9 + int'(cnt);
    return 0;
  endfunction

  task automatic clear_model();
    rx_pos       = '0;
    rx_crc       = CrcInit;
    tail_lo      = '0;
    tail_hi      = '0;
    rx_slave     = '0;
    rx_func      = '0;
    rx_qty       = '0;
    rx_count     = '0;
    rx_crc_state = CrcUndecided;
  endtask

  function automatic verdict_e judge_frame();
    logic good;
    good = (rx_crc_state == CrcMatch);
    if (rx_pos > MaxFrame) return VerdictReject;
    if (rx_func <= FnReadBitsLast)
      return (rx_qty < QtyBitsLimit && good) ? VerdictAccept : VerdictReject;
    if (rx_func <= FnReadRegsLast)
      return (rx_qty < QtyRegsLimit && good) ? VerdictAccept : VerdictReject;
    if (rx_func == FnWriteCoil)
      return ((rx_qty == CoilOn || rx_qty == CoilOff) && good) ? VerdictAccept : VerdictReject;
    if (rx_func == FnWriteReg)
      return good ? VerdictAccept : VerdictReject;
    if (rx_func == FnWriteCoils)
      return (rx_count != 0 && rx_qty != 0 && good) ? VerdictAccept : VerdictReject;
    if (rx_func == FnWriteRegs)
      return (rx_qty != 0 && rx_qty < QtyMultLimit && int'(rx_count) == 2 * int'(rx_qty)
              && good) ? VerdictAccept : VerdictReject;
    if (rx_func == FnUserDefined)
      return (rx_pos >= 3 && {tail_hi, tail_lo} == rx_crc) ? VerdictAccept : VerdictReject;
    return VerdictUnsupported;
  endfunction

  // Fold one accepted word into the shadow; report on the frame end
  task automatic absorb_byte(input logic [7:0] b, input logic last, output logic got,
                             output frame_report_t r);
    int i;
    i   = int'(rx_pos);
    got = 1'b0;
    r   = '0;
    if (i <= MaxFrame) begin
      case (i)
        0: rx_slave = b;
        1: rx_func = b;
        4: rx_qty[15:8] = b;
        5: rx_qty[7:0] = b;
        6: rx_count = b;
        default: ;
      endcase
      if (i < MaxFrame) begin
        // the CRC trails the input by the two held bytes
        if (i >= 2) rx_crc = crc16_byte(rx_crc, tail_lo);
        tail_lo = tail_hi;
        tail_hi = b;
        if (rx_crc_state == CrcUndecided && i + 1 == crc_span(rx_func, rx_count))
          rx_crc_state = ({tail_hi, tail_lo} == rx_crc) ? CrcMatch : CrcMismatch;
      end
      rx_pos = 9'(i + 1);
    end
    if (last) begin
      got          = 1'b1;
      r.verdict    = judge_frame();
      r.addr_match = (rx_slave == own_addr || rx_slave == BroadcastAddr);
      r.func       = rx_func;
      r.length     = rx_pos;
      clear_model();
    end
  endtask

  task automatic note_field(input string what, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
      fault_count++;
    end
  endtask

  // Track accepted words and check each result word against the oldest report
  always @(posedge clk_i) begin : watch
    logic          got;
    frame_report_t r;
    report_hint_t  h;
    frame_report_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      absorb_byte(data_byte_i, frame_end_i, got, r);
      if (got) begin
        if (hint_q.size() != 0) begin
          h = hint_q.pop_front();
          if (h.typed_in) r = h.report;
        end
        report_q.push_back(r);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got verdict %0d length %0d",
                 $time, verdict_o, frame_length_o);
        fault_count++;
      end else begin
        want = report_q.pop_front();
        note_field("verdict", int'(want.verdict), int'(verdict_o));
        note_field("address_match", int'(want.addr_match), int'(address_match_o));
        note_field("function_code", int'(want.func), int'(function_code_o));
        note_field("frame_length", int'(want.length), int'(frame_length_o));
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones; none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_tokens) begin
        hold_served = hold_tokens;
        rx_wait     = HoldCycles;
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
        rx_wait = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_frame(input logic typed_in, input frame_report_t want);
    report_hint_t h;
    h.typed_in = typed_in;
    h.report   = want;
    hint_q.push_back(h);
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  // Lay out a request and seal it with a CRC where the length allows
  task automatic build_frame(input logic [7:0] addr, input logic [7:0] fn,
                             input logic [15:0] qty, input logic [7:0] cnt,
                             input int len, input logic crc_ok);
    int span;
    int k;
    logic [15:0] c;
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom()));
    if (len > 0) frame_q[0] = addr;
    if (len > 1) frame_q[1] = fn;
    if (len > 4) frame_q[4] = qty[15:8];
    if (len > 5) frame_q[5] = qty[7:0];
    if (len > 6) frame_q[6] = cnt;
    span = crc_span(fn, cnt);
    if (span == 0) span = len;
    if (span >= 4 && span <= len && span <= MaxFrame) begin
      c = CrcInit;
      for (k = 0; k < span - 2; k++) c = crc16_byte(c, frame_q[k]);
      if (!crc_ok) c = c ^ 16'h0001;
      frame_q[span-2] = c[7:0];
      frame_q[span-1] = c[15:8];
    end
  endtask

  task automatic add_row(input logic [7:0] addr, input logic [7:0] fn, input logic [15:0] qty,
                         input logic [7:0] cnt, input int len, input logic crc_ok,
                         input logic typed_in, input verdict_e v, input logic am,
                         input logic [7:0] f, input int l);
    frame_row_t row;
    row.addr              = addr;
    row.func              = fn;
    row.qty               = qty;
    row.count             = cnt;
    row.length            = 10'(len);
    row.crc_ok            = crc_ok;
    row.typed_in          = typed_in;
    row.report.verdict    = v;
    row.report.addr_match = am;
    row.report.func       = f;
    row.report.length     = 9'(l);
    rows.push_back(row);
  endtask

  // Mostly well-formed requests with random content, the rest noise
  task automatic random_frame();
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [7:0]  cnt;
    logic [15:0] qty;
    int len, span, shape, mode;
    shape = $urandom_range(0, 99);
    mode  = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0, 1: addr = own_addr;
      2: addr = BroadcastAddr;
      default: addr = 8'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: fn = FnLowest;
      1: fn = FnReadCoils;
      2: fn = FnReadBitsLast;
      3: fn = FnReadHolding;
      4: fn = FnReadRegsLast;
      5: fn = FnWriteCoil;
      6: fn = FnWriteReg;
      7: fn = FnWriteCoils;
      8: fn = FnWriteRegs;
      default: fn = FnUserDefined;
    endcase
    if ($urandom_range(0, 99) < 22) fn = 8'($urandom());
    qty = 16'($urandom());
    cnt = 8'($urandom_range(0, 12));
    // legal, boundary or arbitrary header fields
    if (fn <= FnReadBitsLast) begin
      if (mode < 70) qty = 16'($urandom_range(0, QtyBitsLimit - 1));
      else if (mode < 85) qty = QtyBitsLimit - 16'($urandom_range(0, 1));
    end else if (fn <= FnReadRegsLast) begin
      if (mode < 70) qty = 16'($urandom_range(0, QtyRegsLimit - 1));
      else if (mode < 85) qty = QtyRegsLimit - 16'($urandom_range(0, 1));
    end else if (fn == FnWriteCoil) begin
      if (mode < 70) qty = $urandom_range(0, 1) ? CoilOn : CoilOff;
      else if (mode < 85) qty = $urandom_range(0, 1) ? CoilOn + 16'd1 : CoilOff + 16'd1;
    end else if (fn == FnWriteCoils) begin
      if (mode < 70) begin
        qty = 16'($urandom_range(1, 64));
        cnt = 8'((qty + 16'd7) / 16'd8);
      end else if (mode < 85) begin
        qty = $urandom_range(0, 1) ? 16'd0 : 16'd9;
        cnt = (qty == 16'd0) ? 8'd2 : 8'd0;
      end
    end else if (fn == FnWriteRegs) begin
      if (mode < 70) begin
        qty = 16'($urandom_range(1, 8));
        cnt = 8'(qty * 16'd2);
      end else if (mode < 80) begin
        qty = 16'd0;
        cnt = 8'd0;
      end else if (mode < 84) begin
        qty = QtyMultLimit - 16'($urandom_range(0, 1));
        cnt = 8'(qty * 16'd2);
      end else if (mode < 92) begin
        qty = 16'($urandom_range(1, 5));
        cnt = 8'(qty * 16'd2 + 16'd1);
      end
    end
    span = crc_span(fn, cnt);
    if (span == 0) span = $urandom_range(3, 16);
    if (shape < 80) len = span;
    else if (shape < 90) len = span + $urandom_range(1, 3);
    else len = $urandom_range(1, span - 1);
    if ($urandom_range(0, 99) < 15) len = $urandom_range(1, 24);
    if ($urandom_range(0, 59) == 0) len = $urandom_range(MaxFrame + 1, MaxFrame + 14);
    build_frame(addr, fn, qty, cnt, len, $urandom_range(0, 9) != 0);
    send_frame(1'b0, '0);
  endtask

  // Write the address only once the block has gone quiet
  task automatic set_address(input logic [7:0] a);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    own_addr = a;
  endtask

  initial begin : stimulus
    logic [7:0] addr_plan [Phases];
    int base;
    int ph;
    addr_plan[0] = AddrHigh;
    addr_plan[1] = AddrLow;
    addr_plan[2] = BroadcastAddr;
    addr_plan[3] = 8'hFF;
    addr_plan[4] = 8'($urandom_range(AddrLow, AddrHigh));
    own_addr = DefaultAddr;
    clear_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, run with the address left at its reset value
    add_row(8'd1, FnReadHolding, 16'd10, 8'd0, 8, 1, 1, VerdictAccept, 1, FnReadHolding, 8);
    add_row(8'd1, FnReadHolding, 16'd10, 8'd0, 8, 0, 1, VerdictReject, 1, FnReadHolding, 8);
    add_row(8'd1, FnLowest, 16'd0, 8'd0, 1, 1, 1, VerdictReject, 1, FnLowest, 1);
    add_row(BroadcastAddr, FnWriteReg, 16'hFFFF, 8'd0, 8, 1, 1,
            VerdictAccept, 1, FnWriteReg, 8);
    add_row(8'hFF, FnWriteReg, 16'd0, 8'd0, 8, 1, 1, VerdictAccept, 0, FnWriteReg, 8);
    add_row(8'd1, FnLowest, 16'd253, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnReadCoils, 16'd254, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnReadBitsLast, 16'd0, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnReadRegsLast, 16'd126, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnReadRegsLast, 16'd127, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteCoil, CoilOn, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteCoil, CoilOff, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteCoil, 16'h0001, 8'd0, 8, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteCoils, 16'd8, 8'd1, 10, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteCoils, 16'd1, 8'd0, 9, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteRegs, 16'd2, 8'd4, 13, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteRegs, 16'd2, 8'd3, 12, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnWriteRegs, 16'd125, 8'd250, 259, 1, 1,
            VerdictReject, 1, FnWriteRegs, MaxFrame + 1);
    add_row(8'd1, FnUserDefined, 16'd0, 8'd0, 10, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnUserDefined, 16'd0, 8'd0, 3, 1, 0, VerdictAccept, 0, 0, 0);
    add_row(8'd1, FnUserDefined, 16'd0, 8'd0, 2, 1, 1, VerdictReject, 1, FnUserDefined, 2);
    add_row(8'd1, FnUnknown, 16'd0, 8'd0, 8, 1, 1, VerdictUnsupported, 1, FnUnknown, 8);
    add_row(8'd1, FnTop, 16'd0, 8'd0, 5, 1, 1, VerdictUnsupported, 1, FnTop, 5);
    add_row(8'd1, FnReadHolding, 16'd10, 8'd0, 300, 1, 1,
            VerdictReject, 1, FnReadHolding, MaxFrame + 1);
    add_row(8'd1, FnReadHolding, 16'd10, 8'd0, 7, 1, 1, VerdictReject, 1, FnReadHolding, 7);
    add_row(8'd1, FnReadHolding, 16'd10, 8'd0, 12, 1, 0, VerdictAccept, 0, 0, 0);

    foreach (rows[n]) begin
      build_frame(rows[n].addr, rows[n].func, rows[n].qty, rows[n].count,
                  int'(rows[n].length), rows[n].crc_ok);
      send_frame(rows[n].typed_in, rows[n].report);
    end

    // Random phases, each under its own address; one without stalls
    base = words_sent;
    for (ph = 0; ph < Phases; ph++) begin
      set_address(addr_plan[ph]);
      calm = (ph == 2);
      if (ph == 1 || ph == 3) hold_tokens++;
      while (words_sent < base + (ph + 1) * RandomWords / Phases) random_frame();
    end

    // Drain and report
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
